[rtl/ir_remote_pulse_decoder_assert.svh]
// ----------------------------------------------------------------------------
// IR remote pulse decoder assertion macros
// Shared concurrent assertion forms used by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef IR_REMOTE_PULSE_DECODER_ASSERT_SVH
`define IR_REMOTE_PULSE_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IRPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irpd same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define IRPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irpd next-cycle check failed");

`endif

[rtl/irpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR remote pulse decoder package
// Beat types, configuration layout and phase codes shared by the decoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

    // Input beat: an edge with its interval, or a timer overflow.
    typedef struct packed {
        logic       action;
        logic [7:0] pulse_ticks;
    } in_beat_t;

    // Output beat: one completed frame.
    typedef struct packed {
        logic [7:0] address_byte;
        logic [7:0] command_byte;
    } out_beat_t;

    // Input action codes.
    localparam logic ACT_EDGE    = 1'b0;
    localparam logic ACT_TIMEOUT = 1'b1;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_START_MIN     = 3'd0,
        CFG_START_MAX     = 3'd1,
        CFG_BIT_MIN       = 3'd2,
        CFG_BIT_MAX       = 3'd3,
        CFG_ONE_THRESHOLD = 3'd4
    } cfg_index_t;

    // Reset values of the configuration registers.
    localparam logic [7:0] START_MIN_RST     = 8'd100;
    localparam logic [7:0] START_MAX_RST     = 8'd140;
    localparam logic [7:0] BIT_MIN_RST       = 8'd10;
    localparam logic [7:0] BIT_MAX_RST       = 8'd30;
    localparam logic [7:0] ONE_THRESHOLD_RST = 8'd20;

    // Current configuration as seen by the decode logic.
    typedef struct packed {
        logic [7:0] start_min;
        logic [7:0] start_max;
        logic [7:0] bit_min;
        logic [7:0] bit_max;
        logic [7:0] one_threshold;
    } cfg_t;

    // Decoder phases.
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_START   = 2'd1,
        PH_RECEIVE = 2'd2
    } phase_t;

endpackage

[rtl/irpd_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR remote pulse decoder configuration registers
// Holds the timing windows and the one threshold, written by index.
// ----------------------------------------------------------------------------
module irpd_cfg_regs
    import irpd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write index; unknown indexes leave everything unchanged.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_START_MIN:     cfg_next.start_min     = cfg_data;
                CFG_START_MAX:     cfg_next.start_max     = cfg_data;
                CFG_BIT_MIN:       cfg_next.bit_min       = cfg_data;
                CFG_BIT_MAX:       cfg_next.bit_max       = cfg_data;
                CFG_ONE_THRESHOLD: cfg_next.one_threshold = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // Register bank with documented reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_min     <= START_MIN_RST;
            cfg_reg.start_max     <= START_MAX_RST;
            cfg_reg.bit_min       <= BIT_MIN_RST;
            cfg_reg.bit_max       <= BIT_MAX_RST;
            cfg_reg.one_threshold <= ONE_THRESHOLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/irpd_frame_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR remote pulse decoder frame core
// Phase machine, bit and byte counters and the frame byte store. Each
// accepted beat updates the registered state and may flag a finished frame.
// ----------------------------------------------------------------------------
`include "ir_remote_pulse_decoder_assert.svh"

module irpd_frame_core
    import irpd_pkg::*;
#(
    parameter int FRAME_BYTES = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      beat_valid,
    input  in_beat_t  beat,
    input  cfg_t      cfg,
    output logic      frame_done,
    output out_beat_t frame
);

    localparam int IDX_W = $clog2(FRAME_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);
    localparam logic [2:0] LAST_BIT = 3'd7;

    phase_t           phase_reg;
    phase_t           phase_next;
    logic [2:0]       bit_count_reg;
    logic [2:0]       bit_count_next;
    logic [IDX_W-1:0] byte_index_reg;
    logic [IDX_W-1:0] byte_index_next;
    logic [7:0]       frame_reg  [FRAME_BYTES];
    logic [7:0]       frame_next [FRAME_BYTES];

    logic       start_ok;
    logic       bit_ok;
    logic [7:0] shifted_byte;

    // Window checks; an empty window (min above max) accepts nothing.
    assign start_ok = (beat.pulse_ticks >= cfg.start_min) &&
                      (beat.pulse_ticks <= cfg.start_max);
    assign bit_ok   = (beat.pulse_ticks >= cfg.bit_min) &&
                      (beat.pulse_ticks <= cfg.bit_max);

    // New value of the current byte: bits arrive LSB first from the top.
    assign shifted_byte = {(beat.pulse_ticks > cfg.one_threshold),
                           frame_reg[byte_index_reg][7:1]};

    // Next state and the finished-frame strobe.
    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        byte_index_next = byte_index_reg;
        frame_done      = 1'b0;
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            frame_next[i] = frame_reg[i];
        end

        if (beat_valid)
        begin
            if (beat.action == ACT_TIMEOUT)
            begin
                phase_next = PH_IDLE;
            end
            else
            begin
                case (phase_reg)
                    PH_START:
                    begin
                        if (start_ok)
                        begin
                            bit_count_next  = '0;
                            byte_index_next = '0;
                            for (int i = 0; i < FRAME_BYTES; i++)
                            begin
                                frame_next[i] = '0;
                            end
                            phase_next = PH_RECEIVE;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_RECEIVE:
                    begin
                        if (!bit_ok)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            frame_next[byte_index_reg] = shifted_byte;
                            bit_count_next = bit_count_reg + 3'd1;
                            if (bit_count_reg == LAST_BIT)
                            begin
                                if (byte_index_reg == LAST_IDX)
                                begin
                                    frame_done      = 1'b1;
                                    byte_index_next = '0;
                                    phase_next      = PH_IDLE;
                                end
                                else
                                begin
                                    byte_index_next = byte_index_reg + IDX_W'(1);
                                end
                            end
                        end
                    end
                    // Idle and the unused code both arm the decoder.
                    default:
                    begin
                        phase_next = PH_START;
                    end
                endcase
            end
        end
    end

    // The last byte completes in this beat, so it comes from the shift path.
    assign frame.address_byte = frame_reg[0];
    assign frame.command_byte = shifted_byte;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= '0;
            byte_index_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            byte_index_reg <= byte_index_next;
        end
    end

    // Frame bytes: every byte is shifted eight times before it is read.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            frame_reg[i] <= frame_next[i];
        end
    end

    // A frame finishes only on the eighth bit of the last byte.
    `IRPD_ASSERT_SAME(a_done_at_last_bit, clk, rst_n, frame_done,
        (phase_reg == PH_RECEIVE) && (bit_count_reg == LAST_BIT) &&
        (byte_index_reg == LAST_IDX))
    // After a finished frame the decoder is back to idle with counters clear.
    `IRPD_ASSERT_NEXT(a_idle_after_done, clk, rst_n, frame_done,
        (phase_reg == PH_IDLE) && (bit_count_reg == 3'd0) &&
        (byte_index_reg == '0))
    // A timeout always drops the decoder to idle.
    `IRPD_ASSERT_NEXT(a_timeout_idles, clk, rst_n,
        beat_valid && (beat.action == ACT_TIMEOUT), phase_reg == PH_IDLE)
    // The byte index never runs past the last frame byte.
    `IRPD_ASSERT_SAME(a_index_in_range, clk, rst_n, 1'b1, byte_index_reg <= LAST_IDX)

endmodule

[rtl/ir_remote_pulse_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR remote pulse decoder
// Decodes pulse-distance IR remote frames from edge intervals and timeouts
// and delivers the address and command bytes of each completed frame.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   in      | input     | in_valid / in_stall  | action, pulse_ticks
//   out     | output    | out_valid / out_stall| address_byte, command_byte
//   cfg     | input     | cfg_wr_en            | cfg_index, cfg_data
//
// One input beat is taken every cycle while in_stall is low; the decode state
// updates at the edge that accepts the beat, and a finished frame is loaded
// into out at that same edge. The output register is the only buffer: input
// stalls only while it holds a frame and out_stall is high. Reset returns the
// decoder to idle with the default windows and no clearing pass.
// ----------------------------------------------------------------------------
module ir_remote_pulse_decoder
    import irpd_pkg::*;
#(
    parameter int FRAME_BYTES = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_data,
    input  logic      cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cfg_t      cfg;
    logic      in_accept;
    logic      frame_done;
    out_beat_t frame;

    logic      out_valid_reg;
    logic      out_valid_next;
    out_beat_t out_data_reg;
    out_beat_t out_data_next;

    irpd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input is held off only while a frame waits and the sink stalls.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    irpd_frame_core #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_frame_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (in_accept),
        .beat       (in_data),
        .cfg        (cfg),
        .frame_done (frame_done),
        .frame      (frame)
    );

    // Output register: load a new frame, or drop the beat once taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (frame_done)
        begin
            out_valid_next = 1'b1;
            out_data_next  = frame;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IR remote pulse decoder testbench
// Drives edge and timeout beats into the decoder through a directed table and
// then random frames, noise and broken frames under several window settings
// and idling mixes. The table gives its own frames, an in-bench decoder model
// predicts the rest; each output beat is checked field by field, oldest first.
// ----------------------------------------------------------------------------
module tb;
    import irpd_pkg::*;

    localparam int FRAME_BYTES    = 4;
    localparam int FRAME_BITS     = FRAME_BYTES * 8;
    localparam int DRAIN_CYCLES   = 4;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int END_WAIT_LIMIT = 5000;
    localparam int SEGMENTS       = 8;
    localparam int ITEM_TARGET    = 1150;
    localparam int FRAMES_PER_SEG = 3;

    // Register index past the end of the register list; writes to it are dropped.
    localparam logic [2:0] CFG_UNUSED_INDEX = 3'd5;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_BEAT,
        ROW_FRAME
    } row_kind_t;

    // One line of the directed table.
    typedef struct {
        row_kind_t  kind;
        logic [2:0] index;
        logic [7:0] value;
        in_beat_t   beat;
        out_beat_t  frame;
    } row_t;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_beat_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_beat_t out_data;
    logic      cfg_wr_en = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data  = '0;

    // Decoder model state and its copy of the registers.
    cfg_t       cfg_model;
    phase_t     dec_phase;
    logic [2:0] dec_bit_cnt;
    logic [1:0] dec_byte_idx;
    logic [7:0] dec_frame [FRAME_BYTES];

    out_beat_t frame_expect_q [$];
    row_t      dir_rows [$];

    int n_mismatch     = 0;
    int n_items        = 0;
    int n_frames       = 0;
    int n_cycles       = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    ir_remote_pulse_decoder #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit.
    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        n_mismatch++;
    endtask

    // Advance the decoder model by one input beat; returns 1 when a frame completes.
    function automatic bit decode_beat(input in_beat_t beat, output out_beat_t res);
        logic [7:0] ticks;
        ticks = beat.pulse_ticks;
        res = '0;
        decode_beat = 1'b0;
        if (beat.action == ACT_TIMEOUT)
        begin
            dec_phase = PH_IDLE;
        end
        else
        begin
            case (dec_phase)
                PH_START:
                begin
                    if (ticks >= cfg_model.start_min && ticks <= cfg_model.start_max)
                    begin
                        dec_bit_cnt = '0;
                        dec_byte_idx = '0;
                        foreach (dec_frame[i])
                            dec_frame[i] = '0;
                        dec_phase = PH_RECEIVE;
                    end
                    else
                    begin
                        dec_phase = PH_IDLE;
                    end
                end
                PH_RECEIVE:
                begin
                    if (ticks < cfg_model.bit_min || ticks > cfg_model.bit_max)
                    begin
                        dec_phase = PH_IDLE;
                    end
                    else
                    begin
                        // Bits arrive LSB first, so each new bit enters at the top.
                        dec_frame[dec_byte_idx] = {ticks > cfg_model.one_threshold,
                                                   dec_frame[dec_byte_idx][7:1]};
                        if (dec_bit_cnt == 3'd7)
                        begin
                            dec_bit_cnt = '0;
                            if (dec_byte_idx == FRAME_BYTES - 1)
                            begin
                                res.address_byte = dec_frame[0];
                                res.command_byte = dec_frame[FRAME_BYTES - 1];
                                dec_byte_idx = '0;
                                dec_phase = PH_IDLE;
                                decode_beat = 1'b1;
                            end
                            else
                            begin
                                dec_byte_idx = dec_byte_idx + 2'd1;
                            end
                        end
                        else
                        begin
                            dec_bit_cnt = dec_bit_cnt + 3'd1;
                        end
                    end
                end
                // Idle and the unused phase code both arm the decoder.
                default: dec_phase = PH_START;
            endcase
        end
    endfunction

    // Offer one beat, wait for it to be taken, and record what it should produce.
    task automatic send_beat(input in_beat_t beat, input bit typed, input out_beat_t typed_res);
        out_beat_t pred;
        bit done;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n_items++;
        done = decode_beat(beat, pred);
        if (typed)
            frame_expect_q.push_back(typed_res);
        else if (done)
            frame_expect_q.push_back(pred);
        if (typed || done)
            n_frames++;
    endtask

    function automatic logic [7:0] pick_ticks(input int lo, input int hi);
        if (lo > hi)
            return 8'($urandom_range(255, 0));
        return 8'($urandom_range(hi, lo));
    endfunction

    // Send a frame (or its first nbits bits) with intervals drawn from the current windows.
    task automatic send_frame(input logic [FRAME_BITS-1:0] bits, input int nbits,
                              input bit typed, input out_beat_t res);
        int zero_lo;
        int zero_hi;
        int one_lo;
        int one_hi;
        in_beat_t beat;
        zero_lo = int'(cfg_model.bit_min);
        zero_hi = (cfg_model.bit_max < cfg_model.one_threshold) ?
                  int'(cfg_model.bit_max) : int'(cfg_model.one_threshold);
        one_lo  = (int'(cfg_model.bit_min) > int'(cfg_model.one_threshold)) ?
                  int'(cfg_model.bit_min) : int'(cfg_model.one_threshold) + 1;
        one_hi  = int'(cfg_model.bit_max);
        // When one bit value cannot be coded, fall back to the whole bit window.
        if (zero_lo > zero_hi)
        begin
            zero_lo = int'(cfg_model.bit_min);
            zero_hi = int'(cfg_model.bit_max);
        end
        if (one_lo > one_hi)
        begin
            one_lo = int'(cfg_model.bit_min);
            one_hi = int'(cfg_model.bit_max);
        end
        beat = '0;
        if (dec_phase != PH_IDLE)
        begin
            beat.action = ACT_TIMEOUT;
            send_beat(beat, 1'b0, '0);
        end
        beat.action = ACT_EDGE;
        beat.pulse_ticks = 8'($urandom_range(255, 0));
        send_beat(beat, 1'b0, '0);
        beat.pulse_ticks = pick_ticks(int'(cfg_model.start_min), int'(cfg_model.start_max));
        send_beat(beat, 1'b0, '0);
        for (int i = 0; i < nbits; i++)
        begin
            beat.pulse_ticks = bits[i] ? pick_ticks(one_lo, one_hi) : pick_ticks(zero_lo, zero_hi);
            send_beat(beat, typed && i == FRAME_BITS - 1, res);
        end
    endtask

    task automatic send_noise();
        in_beat_t beat;
        beat.action = $urandom_range(0, 1) ? ACT_TIMEOUT : ACT_EDGE;
        beat.pulse_ticks = 8'($urandom_range(255, 0));
        send_beat(beat, 1'b0, '0);
    endtask

    // Stop sending and wait until every predicted frame has come out.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (frame_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] index, input logic [7:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        case (index)
            CFG_START_MIN:     cfg_model.start_min = value;
            CFG_START_MAX:     cfg_model.start_max = value;
            CFG_BIT_MIN:       cfg_model.bit_min = value;
            CFG_BIT_MAX:       cfg_model.bit_max = value;
            CFG_ONE_THRESHOLD: cfg_model.one_threshold = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_setting(input logic [7:0] s_min, input logic [7:0] s_max,
                                 input logic [7:0] b_min, input logic [7:0] b_max,
                                 input logic [7:0] thr);
        cfg_write(CFG_START_MIN, s_min);
        cfg_write(CFG_START_MAX, s_max);
        cfg_write(CFG_BIT_MIN, b_min);
        cfg_write(CFG_BIT_MAX, b_max);
        cfg_write(CFG_ONE_THRESHOLD, thr);
    endtask

    function automatic row_t row_beat(input logic act, input logic [7:0] ticks);
        row_t r;
        r = '{ROW_BEAT, '0, '0, '0, '0};
        r.beat.action = act;
        r.beat.pulse_ticks = ticks;
        return r;
    endfunction

    function automatic row_t row_cfg(input logic [2:0] index, input logic [7:0] value);
        row_t r;
        r = '{ROW_CFG, index, value, '0, '0};
        return r;
    endfunction

    function automatic row_t row_frame(input logic [7:0] addr, input logic [7:0] cmd);
        row_t r;
        r = '{ROW_FRAME, '0, '0, '0, '0};
        r.frame.address_byte = addr;
        r.frame.command_byte = cmd;
        return r;
    endfunction

    // Receiver stalls, drawn anew each cycle.
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    // Frame checker.
    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (frame_expect_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected frame addr %02h cmd %02h",
                                          out_data.address_byte, out_data.command_byte));
            end
            else
            begin
                want = frame_expect_q.pop_front();
                if (out_data.address_byte !== want.address_byte)
                    report_mismatch($sformatf("address_byte %02h, expected %02h",
                                              out_data.address_byte, want.address_byte));
                if (out_data.command_byte !== want.command_byte)
                    report_mismatch($sformatf("command_byte %02h, expected %02h",
                                              out_data.command_byte, want.command_byte));
            end
        end
    end

    // Stimulus.
    initial
    begin
        row_t r;
        int pick;
        int item_base;
        int frame_base;
        int wait_cnt;
        int s_min;
        int b_min;
        int b_max;

        cfg_model = '{START_MIN_RST, START_MAX_RST, BIT_MIN_RST, BIT_MAX_RST, ONE_THRESHOLD_RST};
        dec_phase = PH_IDLE;
        dec_bit_cnt = '0;
        dec_byte_idx = '0;
        foreach (dec_frame[i])
            dec_frame[i] = '0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table, starting from the reset windows.
        dir_rows.push_back(row_beat(ACT_TIMEOUT, 8'd0));     // timeout while idle
        dir_rows.push_back(row_frame(8'h00, 8'hFF));
        dir_rows.push_back(row_frame(8'hFF, 8'h00));
        dir_rows.push_back(row_beat(ACT_EDGE, 8'd255));      // arming edge ignores ticks
        dir_rows.push_back(row_beat(ACT_EDGE, 8'd99));       // start just too short
        dir_rows.push_back(row_beat(ACT_EDGE, 8'd0));
        dir_rows.push_back(row_beat(ACT_EDGE, 8'd141));      // start just too long
        dir_rows.push_back(row_beat(ACT_EDGE, 8'd0));
        dir_rows.push_back(row_beat(ACT_EDGE, 8'd100));      // start at the low edge
        dir_rows.push_back(row_beat(ACT_EDGE, 8'd9));        // bit too short
        dir_rows.push_back(row_beat(ACT_EDGE, 8'd0));
        dir_rows.push_back(row_beat(ACT_EDGE, 8'd140));      // start at the high edge
        dir_rows.push_back(row_beat(ACT_EDGE, 8'd30));
        dir_rows.push_back(row_beat(ACT_EDGE, 8'd20));       // at the threshold: zero
        dir_rows.push_back(row_beat(ACT_EDGE, 8'd31));       // bit too long
        dir_rows.push_back(row_beat(ACT_EDGE, 8'd7));
        dir_rows.push_back(row_beat(ACT_TIMEOUT, 8'd255));   // timeout in start phase
        dir_rows.push_back(row_beat(ACT_EDGE, 8'd0));
        dir_rows.push_back(row_beat(ACT_EDGE, 8'd120));
        dir_rows.push_back(row_beat(ACT_EDGE, 8'd10));
        dir_rows.push_back(row_beat(ACT_TIMEOUT, 8'd0));     // timeout while receiving
        // Widest windows, threshold at zero.
        dir_rows.push_back(row_cfg(CFG_START_MIN, 8'd0));
        dir_rows.push_back(row_cfg(CFG_START_MAX, 8'd255));
        dir_rows.push_back(row_cfg(CFG_BIT_MIN, 8'd0));
        dir_rows.push_back(row_cfg(CFG_BIT_MAX, 8'd255));
        dir_rows.push_back(row_cfg(CFG_ONE_THRESHOLD, 8'd0));
        dir_rows.push_back(row_frame(8'h5A, 8'hC3));
        // Empty bit window: a good start, then every bit is rejected.
        dir_rows.push_back(row_cfg(CFG_BIT_MIN, 8'd200));
        dir_rows.push_back(row_cfg(CFG_BIT_MAX, 8'd100));
        dir_rows.push_back(row_cfg(CFG_UNUSED_INDEX, 8'd0));
        dir_rows.push_back(row_beat(ACT_EDGE, 8'd0));
        dir_rows.push_back(row_beat(ACT_EDGE, 8'd0));
        dir_rows.push_back(row_beat(ACT_EDGE, 8'd150));
        // Empty start window.
        dir_rows.push_back(row_cfg(CFG_START_MIN, 8'd200));
        dir_rows.push_back(row_cfg(CFG_START_MAX, 8'd100));
        dir_rows.push_back(row_beat(ACT_EDGE, 8'd0));
        dir_rows.push_back(row_beat(ACT_EDGE, 8'd150));

        foreach (dir_rows[i])
        begin
            r = dir_rows[i];
            case (r.kind)
                ROW_CFG:
                begin
                    settle();
                    cfg_write(r.index, r.value);
                end
                ROW_BEAT: send_beat(r.beat, 1'b0, '0);
                default:
                    send_frame({r.frame.command_byte, ~r.frame.command_byte,
                                ~r.frame.address_byte, r.frame.address_byte},
                               FRAME_BITS, 1'b1, r.frame);
            endcase
        end

        // Random part: one window setting and one idling mix per segment.
        item_base = n_items;
        frame_base = n_frames;
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            settle();
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            case (seg)
                0: apply_setting(START_MIN_RST, START_MAX_RST, BIT_MIN_RST, BIT_MAX_RST,
                                 ONE_THRESHOLD_RST);
                1: apply_setting(8'd0, 8'd255, 8'd0, 8'd255, 8'd0);
                6: apply_setting(8'd0, 8'd255, 8'd0, 8'd255, 8'd255);
                7: apply_setting(8'd255, 8'd255, 8'd255, 8'd255, 8'd254);
                default:
                begin
                    s_min = $urandom_range(200, 0);
                    b_min = $urandom_range(100, 0);
                    b_max = $urandom_range(255, b_min + 20);
                    apply_setting(8'(s_min), 8'($urandom_range(255, s_min)), 8'(b_min),
                                  8'(b_max), 8'($urandom_range(b_max, b_min)));
                end
            endcase
            while (n_items - item_base < (seg + 1) * ITEM_TARGET / SEGMENTS ||
                   n_frames - frame_base < (seg + 1) * FRAMES_PER_SEG)
            begin
                pick = $urandom_range(99, 0);
                if (pick < 70)
                begin
                    send_frame($urandom, FRAME_BITS, 1'b0, '0);
                end
                else if (pick < 82)
                begin
                    // Frame cut short by a timeout or a stray interval.
                    send_frame($urandom, $urandom_range(FRAME_BITS - 1, 0), 1'b0, '0);
                    send_noise();
                end
                else
                begin
                    repeat ($urandom_range(4, 1)) send_noise();
                end
                if ($urandom_range(24, 0) == 0)
                    settle();
            end
        end

        // Let the last frames out, then give the verdict.
        recv_stall_pct = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        wait_cnt = 0;
        while (frame_expect_q.size() != 0 && wait_cnt < END_WAIT_LIMIT)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (frame_expect_q.size() != 0)
            report_mismatch($sformatf("%0d frames never came out", frame_expect_q.size()));
        if (n_mismatch == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/irpd_pkg.sv
rtl/irpd_cfg_regs.sv
rtl/irpd_frame_core.sv
rtl/ir_remote_pulse_decoder.sv
bench/tb.sv
